@@ hdl/valr_pkg.sv @@
package valr_pkg;

  // Pipeline depths of the submodules
  localparam int NormLat = 66;
  localparam int DivLat  = 36;

  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  // Result kind
  localparam logic [1:0] CASE_GEN = 2'd0;
  localparam logic [1:0] CASE_PAR = 2'd1;
  localparam logic [1:0] CASE_OPP = 2'd2;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // One digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    logic [35:0] r2;
    logic [35:0] t;
    sqrt_t       res;
    r2 = {cur.rem, pair};
    t  = {2'b00, cur.root, 2'b01};
    if (r2 >= t) begin
      res.rem  = 34'(r2 - t);
      res.root = {cur.root[30:0], 1'b1};
    end else begin
      res.rem  = r2[33:0];
      res.root = {cur.root[30:0], 1'b0};
    end
    return res;
  endfunction

  // Round a Q4.60 sum to Q2.30, halves away from zero
  function automatic logic signed [33:0] rnd_shr30(logic signed [63:0] x);
    logic [63:0] mag;
    logic [33:0] q;
    mag = x[63] ? $unsigned(-x) : $unsigned(x);
    mag = mag + 64'd536870912;
    q   = mag[63:30];
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  // Round Q2.30 to Q2.14 and saturate
  function automatic logic signed [15:0] to_q14(logic signed [37:0] m);
    logic [37:0] mag;
    logic [21:0] r;
    logic signed [15:0] res;
    mag = m[37] ? $unsigned(-m) : $unsigned(m);
    r   = 22'((mag + 38'd32768) >> 16);
    if (m[37]) begin
      if (r > 22'd32768) res = 16'sh8000;
      else res = -$signed(r[15:0]);
    end else begin
      if (r > 22'd32767) res = 16'sh7fff;
      else res = $signed(r[15:0]);
    end
    return res;
  endfunction

endpackage

@@ hdl/vector_align_rotation.sv @@
// Pipeline depth comes mostly from the two iterative units: a 32-stage square root
// plus a 31-stage divider per vector, then a 34-stage divider for the quadratic terms.
// Throughput: one vector pair per cycle; a stalled output holds the whole pipe.
// Reset clears all valid bits and loads the margin register with 128.
module vector_align_rotation import valr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [20:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] src_x_i,
  input  logic signed [15:0] src_y_i,
  input  logic signed [15:0] src_z_i,
  input  logic signed [15:0] dst_x_i,
  input  logic signed [15:0] dst_y_i,
  input  logic signed [15:0] dst_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic        [1:0]  case_code_o
);

  localparam int TotLat = NormLat + 4 + DivLat + 1;

  logic        adv;
  logic [20:0] margin_q;
  logic        vld_q [0:TotLat-1];

  logic signed [31:0] ua [3];
  logic signed [31:0] ub [3];

  logic signed [63:0] prod_q [3][3];
  logic signed [33:0] c_q;
  logic signed [33:0] v2_q [3];
  logic signed [33:0] v3_q [3];
  logic signed [63:0] vv_q [6];
  logic        [31:0] d3_q;
  logic        [1:0]  case3_q;
  logic signed [63:0] sq_q [6];
  logic        [31:0] d4_q;
  logic signed [33:0] v4_q [3];
  logic        [1:0]  case4_q;
  logic signed [33:0] vdly_q [1:DivLat][3];
  logic        [1:0]  cdly_q [1:DivLat];
  logic signed [35:0] quo [6];

  logic signed [15:0] m_q [9];
  logic        [1:0]  case_q;

  // Whole pipe moves unless a finished result waits
  assign adv        = !vld_q[TotLat-1] || out_ready_i;
  assign in_ready_o = adv;

  // Margin register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 21'd128;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TotLat; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < TotLat; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Normalize both vectors
  valr_norm u_norm_src (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (src_x_i),
    .y_i   (src_y_i),
    .z_i   (src_z_i),
    .ux_o  (ua[0]),
    .uy_o  (ua[1]),
    .uz_o  (ua[2])
  );

  valr_norm u_norm_dst (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (dst_x_i),
    .y_i   (dst_y_i),
    .z_i   (dst_z_i),
    .ux_o  (ub[0]),
    .uy_o  (ub[1]),
    .uz_o  (ub[2])
  );

  // All pairwise products of the unit vectors
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod_q[i][j] <= 64'(ua[i]) * 64'(ub[j]);
      end
    end
  end

  // Dot and cross products, rounded to Q2.30
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q     <= rnd_shr30(prod_q[0][0] + prod_q[1][1] + prod_q[2][2]);
      v2_q[0] <= rnd_shr30(prod_q[1][2] - prod_q[2][1]);
      v2_q[1] <= rnd_shr30(prod_q[2][0] - prod_q[0][2]);
      v2_q[2] <= rnd_shr30(prod_q[0][1] - prod_q[1][0]);
    end
  end

  // Classify, form the denominator, square the cross product
  logic signed [33:0] d_full;
  logic [1:0]         case_d;
  assign d_full = OneQ30 + c_q;

  always_comb begin
    if (c_q > OneQ30 - $signed({13'd0, margin_q})) case_d = CASE_PAR;
    else if (c_q < -OneQ30 + $signed({13'd0, margin_q})) case_d = CASE_OPP;
    else case_d = CASE_GEN;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      case3_q <= case_d;
      d3_q    <= (d_full < 34'sd1) ? 32'd1 : d_full[31:0];
      v3_q    <= v2_q;
      vv_q[0] <= 64'(v2_q[0]) * 64'(v2_q[0]);
      vv_q[1] <= 64'(v2_q[1]) * 64'(v2_q[1]);
      vv_q[2] <= 64'(v2_q[2]) * 64'(v2_q[2]);
      vv_q[3] <= 64'(v2_q[0]) * 64'(v2_q[1]);
      vv_q[4] <= 64'(v2_q[0]) * 64'(v2_q[2]);
      vv_q[5] <= 64'(v2_q[1]) * 64'(v2_q[2]);
    end
  end

  // Entries of [v]x^2 at Q4.60
  logic signed [63:0] nv2;
  assign nv2 = vv_q[0] + vv_q[1] + vv_q[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= vv_q[0] - nv2;
      sq_q[1] <= vv_q[1] - nv2;
      sq_q[2] <= vv_q[2] - nv2;
      sq_q[3] <= vv_q[3];
      sq_q[4] <= vv_q[4];
      sq_q[5] <= vv_q[5];
      d4_q    <= d3_q;
      v4_q    <= v3_q;
      case4_q <= case3_q;
    end
  end

  // Divide by 1 + c
  for (genvar n = 0; n < 6; n++) begin : g_rdiv
    valr_rdiv u_rdiv (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (sq_q[n]),
      .den_i (d4_q),
      .quo_o (quo[n])
    );
  end

  // Carry v and the case alongside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vdly_q[1] <= v4_q;
      cdly_q[1] <= case4_q;
      for (int s = 2; s <= DivLat; s++) begin
        vdly_q[s] <= vdly_q[s-1];
        cdly_q[s] <= cdly_q[s-1];
      end
    end
  end

  // Assemble I + [v]x + [v]x^2/(1+c) and round to Q2.14; the parallel and opposite cases give +I and -I
  logic signed [35:0] qm [9];
  logic signed [33:0] vx [9];
  logic signed [15:0] m_d [9];
  logic signed [37:0] msum;

  always_comb begin
    qm[0] = quo[0]; qm[1] = quo[3]; qm[2] = quo[4];
    qm[3] = quo[3]; qm[4] = quo[1]; qm[5] = quo[5];
    qm[6] = quo[4]; qm[7] = quo[5]; qm[8] = quo[2];
    vx[0] = '0;                   vx[1] = -vdly_q[DivLat][2]; vx[2] = vdly_q[DivLat][1];
    vx[3] = vdly_q[DivLat][2];    vx[4] = '0;                 vx[5] = -vdly_q[DivLat][0];
    vx[6] = -vdly_q[DivLat][1];   vx[7] = vdly_q[DivLat][0];  vx[8] = '0;
    msum = '0;
    for (int e = 0; e < 9; e++) begin
      msum = 38'(qm[e]) + 38'(vx[e]) + ((e % 4 == 0) ? 38'(OneQ30) : 38'sd0);
      case (cdly_q[DivLat])
        CASE_PAR: m_d[e] = (e % 4 == 0) ? 16'sd16384 : 16'sd0;
        CASE_OPP: m_d[e] = (e % 4 == 0) ? -16'sd16384 : 16'sd0;
        default:  m_d[e] = to_q14(msum);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q    <= m_d;
      case_q <= cdly_q[DivLat];
    end
  end

  assign out_valid_o = vld_q[TotLat-1];
  assign case_code_o = case_q;
  assign m00_o = m_q[0];
  assign m01_o = m_q[1];
  assign m02_o = m_q[2];
  assign m10_o = m_q[3];
  assign m11_o = m_q[4];
  assign m12_o = m_q[5];
  assign m20_o = m_q[6];
  assign m21_o = m_q[7];
  assign m22_o = m_q[8];

endmodule

@@ hdl/valr_norm.sv @@
module valr_norm import valr_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  output logic signed [31:0] ux_o,
  output logic signed [31:0] uy_o,
  output logic signed [31:0] uz_o
);

  logic signed [31:0] sqx, sqy, sqz;
  logic        [31:0] n2_d;
  logic        [31:0] n2_q  [0:15];
  logic signed [15:0] cmp_q [0:32][3];
  sqrt_t              sq_q  [1:32];

  logic [61:0] rem_q [0:31][3];
  logic [30:0] quo_q [1:31][3];
  logic        neg_q [0:31][3];
  logic [31:0] den_q [0:31];

  // Squared length, exact
  assign sqx  = x_i * x_i;
  assign sqy  = y_i * y_i;
  assign sqz  = z_i * z_i;
  assign n2_d = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q[0]     <= n2_d;
      cmp_q[0][0] <= x_i;
      cmp_q[0][1] <= y_i;
      cmp_q[0][2] <= z_i;
    end
  end

  // Square root of n2 * 2^32, one root bit per stage
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    sqrt_t      cur;
    logic [1:0] pair;
    if (j == 0) begin : g_first
      assign cur = '0;
    end else begin : g_next
      assign cur = sq_q[j];
    end
    if (j <= 15) begin : g_hi
      assign pair = n2_q[j][2*(15-j)+1 -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end
    if (j <= 14) begin : g_n2
      always_ff @(posedge clk_i) begin
        if (en_i) n2_q[j+1] <= n2_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j+1]  <= sqrt_step(cur, pair);
        cmp_q[j+1] <= cmp_q[j];
      end
    end
  end

  // Set up the divisions: numerator |x| * 2^46 + s/2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= sq_q[32].root;
      for (int i = 0; i < 3; i++) begin
        neg_q[0][i] <= cmp_q[32][i][15];
        rem_q[0][i] <= {(cmp_q[32][i][15] ? 16'(-cmp_q[32][i]) : 16'(cmp_q[32][i])), 46'd0}
                       + 62'(sq_q[32].root >> 1);
      end
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < 31; k++) begin : g_div
    logic [62:0] sub [3];
    logic        hit [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign sub[i] = 63'(den_q[k]) << (30 - k);
      assign hit[i] = {1'b0, rem_q[k][i]} >= sub[i];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1][i] <= hit[i] ? 62'({1'b0, rem_q[k][i]} - sub[i]) : rem_q[k][i];
          neg_q[k+1][i] <= neg_q[k][i];
        end
      end
      if (k == 0) begin : g_q0
        always_ff @(posedge clk_i) begin
          if (en_i) quo_q[1][i] <= {30'd0, hit[i]};
        end
      end else begin : g_qn
        always_ff @(posedge clk_i) begin
          if (en_i) quo_q[k+1][i] <= {quo_q[k][i][29:0], hit[i]};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) den_q[k+1] <= den_q[k];
    end
  end

  // Apply sign; a zero vector stays zero
  logic signed [31:0] unit_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (den_q[31] == 32'd0) unit_q[i] <= '0;
        else if (neg_q[31][i]) unit_q[i] <= -$signed({1'b0, quo_q[31][i]});
        else unit_q[i] <= $signed({1'b0, quo_q[31][i]});
      end
    end
  end

  assign ux_o = unit_q[0];
  assign uy_o = unit_q[1];
  assign uz_o = unit_q[2];

endmodule

@@ hdl/valr_rdiv.sv @@
module valr_rdiv import valr_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] num_i,
  input  logic        [31:0] den_i,
  output logic signed [35:0] quo_o
);

  logic [63:0] mag;
  logic [63:0] nm;
  logic [65:0] rem_q [0:34];
  logic [33:0] quo_q [1:34];
  logic [31:0] den_q [0:34];
  logic        neg_q [0:34];
  logic        ovf_q [0:34];
  logic [33:0] qq;
  logic signed [35:0] res_q;

  // Magnitude plus half the divisor; flag quotients that surely saturate
  assign mag = num_i[63] ? $unsigned(-num_i) : $unsigned(num_i);
  assign nm  = mag + 64'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {2'b00, nm};
      den_q[0] <= den_i;
      neg_q[0] <= num_i[63];
      ovf_q[0] <= {2'b00, nm} >= {den_i, 34'd0};
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < 34; k++) begin : g_div
    logic [65:0] sub;
    logic        hit;
    assign sub = 66'(den_q[k]) << (33 - k);
    assign hit = rem_q[k] >= sub;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= hit ? rem_q[k] - sub : rem_q[k];
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
    if (k == 0) begin : g_q0
      always_ff @(posedge clk_i) begin
        if (en_i) quo_q[1] <= {33'd0, hit};
      end
    end else begin : g_qn
      always_ff @(posedge clk_i) begin
        if (en_i) quo_q[k+1] <= {quo_q[k][32:0], hit};
      end
    end
  end

  // Clamp and sign the quotient
  assign qq = ovf_q[34] ? '1 : quo_q[34];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q[34] ? -$signed({2'b00, qq}) : $signed({2'b00, qq});
    end
  end

  assign quo_o = res_q;

endmodule

@@ dv/rotation_checker.sv @@
`timescale 1ns / 1ps

module rotation_checker import valr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [20:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] src_x_i,
  input  logic signed [15:0] src_y_i,
  input  logic signed [15:0] src_z_i,
  input  logic signed [15:0] dst_x_i,
  input  logic signed [15:0] dst_y_i,
  input  logic signed [15:0] dst_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m20_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  input  logic        [1:0]  case_code_i,
  output int                 fail_count_o,
  output int                 rotations_left_o
);

  localparam longint OneQ30L = 64'sd1073741824;

  typedef struct {
    logic signed [15:0] m [9];
    logic [1:0]         kind;
  } rotation_t;

  rotation_t   rotations_due [$];
  logic [20:0] margin_q;

  // Integer square root, one bit pair per step
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Divide with rounding to nearest, halves away from zero
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Scale a vector to unit length in Q2.30; zero stays zero
  function automatic void unit_q30(input longint vec [3], output longint u [3]);
    longint unsigned n2;
    longint unsigned s;
    longint unsigned mag;
    n2 = 0;
    for (int i = 0; i < 3; i++) n2 += longint'(vec[i] * vec[i]);
    if (n2 == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
    end else begin
      s = root64(n2 << 32);
      for (int i = 0; i < 3; i++) begin
        mag  = (vec[i] < 0) ? -vec[i] : vec[i];
        mag  = ((mag << 46) + s / 2) / s;
        u[i] = (vec[i] < 0) ? -longint'(mag) : longint'(mag);
      end
    end
  endfunction

  function automatic logic signed [15:0] sat_q14(longint q30);
    longint r;
    r = round_div(q30, 65536);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic rotation_t predict_rotation(longint src [3], longint dst [3],
                                                 longint margin);
    rotation_t res;
    longint a [3];
    longint b [3];
    longint v [3];
    longint vx [3][3];
    longint c, d, nv2, sq, ent;
    logic par;
    unit_q30(src, a);
    unit_q30(dst, b);
    c = round_div(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], OneQ30L);
    if (c > OneQ30L - margin || c < -OneQ30L + margin) begin
      par = (c > OneQ30L - margin);
      for (int k = 0; k < 9; k++)
        res.m[k] = (k % 4 == 0) ? (par ? 16'sd16384 : -16'sd16384) : 16'sd0;
      res.kind = par ? CASE_PAR : CASE_OPP;
    end else begin
      d = OneQ30L + c;
      if (d < 1) d = 1;
      v[0] = round_div(a[1] * b[2] - a[2] * b[1], OneQ30L);
      v[1] = round_div(a[2] * b[0] - a[0] * b[2], OneQ30L);
      v[2] = round_div(a[0] * b[1] - a[1] * b[0], OneQ30L);
      nv2  = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      vx[0][0] = 0;     vx[0][1] = -v[2]; vx[0][2] = v[1];
      vx[1][0] = v[2];  vx[1][1] = 0;     vx[1][2] = -v[0];
      vx[2][0] = -v[1]; vx[2][1] = v[0];  vx[2][2] = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          sq  = v[i] * v[j] - ((i == j) ? nv2 : 0);
          ent = ((i == j) ? OneQ30L : 0) + vx[i][j] + round_div(sq, d);
          res.m[i * 3 + j] = sat_q14(ent);
        end
      res.kind = CASE_GEN;
    end
    return res;
  endfunction

  // Track the margin, predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    rotation_t exp_r;
    logic signed [15:0] got [9];
    longint src [3];
    longint dst [3];
    if (!rst_ni) begin
      margin_q <= 21'd128;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};
        if (rotations_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual case %0d",
                   $time, case_code_i);
          fail_count_o++;
        end else begin
          exp_r = rotations_due.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== exp_r.m[k]) begin
              $display("%0t: m%0d%0d mismatch, expected %0d, actual %0d",
                       $time, k / 3, k % 3, exp_r.m[k], got[k]);
              fail_count_o++;
            end
          if (case_code_i !== exp_r.kind) begin
            $display("%0t: case_code mismatch, expected %0d, actual %0d",
                     $time, exp_r.kind, case_code_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        src = '{src_x_i, src_y_i, src_z_i};
        dst = '{dst_x_i, dst_y_i, dst_z_i};
        rotations_due.push_back(predict_rotation(src, dst, longint'(margin_q)));
      end
      if (cfg_we_i) margin_q <= cfg_wdata_i;
    end
    rotations_left_o = rotations_due.size();
  end

  initial begin
    fail_count_o     = 0;
    rotations_left_o = 0;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import valr_pkg::*;;

  localparam int StallLimit = 5000;
  localparam int DrainWait  = 150;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic        [20:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] src_x_i = '0, src_y_i = '0, src_z_i = '0;
  logic signed [15:0] dst_x_i = '0, dst_y_i = '0, dst_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic        [1:0]  case_code_o;
  int                 fail_count;
  int                 rotations_left;
  logic               calm = 1'b0;
  int                 idle_cycles = 0;

  vector_align_rotation DUT (.*);

  rotation_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .src_x_i, .src_y_i, .src_z_i, .dst_x_i, .dst_y_i, .dst_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .m00_i(m00_o), .m01_i(m01_o), .m02_i(m02_o),
    .m10_i(m10_o), .m11_i(m11_o), .m12_i(m12_o),
    .m20_i(m20_o), .m21_i(m21_o), .m22_i(m22_o),
    .case_code_i(case_code_o),
    .fail_count_o(fail_count), .rotations_left_o(rotations_left)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("vector_align_rotation test failed");
      $finish;
    end
  end

  // Present one vector pair and hold it until the transfer
  task automatic send_pair(input int sx, input int sy, input int sz,
                           input int dx, input int dy, input int dz);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    src_x_i = 16'(sx); src_y_i = 16'(sy); src_z_i = 16'(sz);
    dst_x_i = 16'(dx); dst_y_i = 16'(dy); dst_z_i = 16'(dz);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drain the pipe, then write the margin
  task automatic write_margin(input logic [20:0] value);
    in_valid_i = 1'b0;
    while (rotations_left != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_pairs(input int count);
    int sx, sy, sz, lo, hi;
    for (int n = 0; n < count; n++) begin
      sx = $urandom_range(0, 32000) - 16000;
      sy = $urandom_range(0, 32000) - 16000;
      sz = $urandom_range(0, 32000) - 16000;
      case ($urandom_range(0, 4))
        0: send_pair($signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)));
        // Near-parallel pair
        1: send_pair(sx, sy, sz, sx + $urandom_range(0, 8) - 4,
                     sy + $urandom_range(0, 8) - 4, sz + $urandom_range(0, 8) - 4);
        // Near-opposite pair
        2: send_pair(sx, sy, sz, -sx + $urandom_range(0, 8) - 4,
                     -sy + $urandom_range(0, 8) - 4, -sz + $urandom_range(0, 8) - 4);
        // Tiny components, zero vectors included
        3: send_pair($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
                     $urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
                     $urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2);
        default: begin
          lo = -32768;
          hi = 32767;
          send_pair(($urandom_range(0, 1) != 0) ? lo : hi, sy, sz,
                    ($urandom_range(0, 1) != 0) ? lo : hi, -sy, sx);
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero vectors, parallel, opposite, extremes, saturation
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, -5, 7);
    send_pair(1, 0, 0, 1, 0, 0);
    send_pair(1, 0, 0, -1, 0, 0);
    send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(-32768, 0, 0, 0, 32767, 0);
    send_pair(1, 2, 3, -3, 1, -2);
    send_pair(0, 0, 1, 0, 1, 0);
    send_pair(100, 0, 0, -100, 1, 0);
    send_pair(30000, 0, 0, -30000, 3, 1);
    send_pair(32767, -32768, 1, -1, 32767, -32768);
    send_pair(-21846, 21845, -1, 21845, -21846, 0);

    // Zero margin: exact opposite falls to the clamped denominator
    write_margin(21'd0);
    send_pair(1, 0, 0, -1, 0, 0);
    send_pair(0, -7, 0, 0, 7, 0);
    send_pair(3, 4, 0, 3, 4, 0);
    send_pair(0, 0, 0, 1, 1, 1);
    random_pairs(200);

    // Widest margin
    write_margin(21'd1048576);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(1, 0, 0, 1, 1, 0);
    random_pairs(200);

    write_margin(21'($urandom_range(0, 1048576)));
    random_pairs(100);
    in_valid_i = 1'b0;
    while (rotations_left != 0) @(negedge clk_i);
    random_pairs(100);

    write_margin(21'($urandom_range(0, 4096)));
    random_pairs(130);

    write_margin(21'd128);
    calm = 1'b1;
    random_pairs(150);
    in_valid_i = 1'b0;

    while (rotations_left != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("vector_align_rotation test passed");
    end else begin
      $display("vector_align_rotation test failed");
    end
    $finish;
  end

endmodule
